// ===== rtl/dts_pkg.sv =====
// Shared types and constants of the depth-to-space address generator.
// No dependencies; every other file of the block imports this package.
package dts_pkg;

  // Fixed widths of the address and element paths
  localparam int unsigned ADDR_BITS = 32;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned OADDR_W   = 32;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_BATCH_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_CHANNELS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_UPSCALE      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DCR_MODE     = 3'd6;

  // Intermediate widths of the index arithmetic
  localparam int unsigned T1_W  = 20;  // batch*oc + dest_channel
  localparam int unsigned DIM_W = 18;  // in_size * upscale
  localparam int unsigned OFS_W = 17;  // coarse*upscale + sub offset
  localparam int unsigned T2_W  = 39;  // t1*oh + row offset
  localparam int unsigned IDX_W = 58;  // full output index

  // Masks for the address and element widths
  localparam logic [IDX_W-1:0] ADDR_MASK =
    (ADDR_BITS >= IDX_W) ? {IDX_W{1'b1}} : IDX_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [ELEM_W-1:0] DATA_MASK =
    (DATA_BITS >= ELEM_W) ? {ELEM_W{1'b1}} : ELEM_W'((64'd1 << DATA_BITS) - 64'd1);

  // Effective (clamped) configuration
  typedef struct packed {
    logic [6:0]  nb;
    logic [12:0] ic;
    logic [12:0] ih;
    logic [12:0] iw;
    logic [12:0] oc;
    logic [4:0]  r;
    logic        dcr;
  } dts_cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // take request, run first stage, step counters
    logic mul_hi;    // second multiply stage
    logic load_out;  // final multiply into the output register
  } dts_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } dts_sts_t;

endpackage

// ===== rtl/dts_cfg.sv =====
// Configuration register file with zero/over-range clamping.
// Depends on dts_pkg.
module dts_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dts_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output dts_pkg::dts_cfg_t              cfg_o
);
  import dts_pkg::*;

  logic [6:0]  batch_count_q;
  logic [12:0] in_channels_q, in_height_q, in_width_q, out_channels_q;
  logic [4:0]  upscale_q;
  logic        dcr_mode_q;
  logic        wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_count_q  <= 7'd1;
      in_channels_q  <= 13'd4;
      in_height_q    <= 13'd1;
      in_width_q     <= 13'd1;
      out_channels_q <= 13'd1;
      upscale_q      <= 5'd2;
      dcr_mode_q     <= 1'b1;
    end else if (wr) begin
      case (cfg_index_i)
        REG_BATCH_COUNT:  batch_count_q  <= cfg_data_i[6:0];
        REG_IN_CHANNELS:  in_channels_q  <= cfg_data_i;
        REG_IN_HEIGHT:    in_height_q    <= cfg_data_i;
        REG_IN_WIDTH:     in_width_q     <= cfg_data_i;
        REG_OUT_CHANNELS: out_channels_q <= cfg_data_i;
        REG_UPSCALE:      upscale_q      <= cfg_data_i[4:0];
        REG_DCR_MODE:     dcr_mode_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Zero acts as one, above range acts as the bound
  function automatic logic [12:0] clamp_size(input logic [12:0] v);
    if (v == 13'd0) return 13'd1;
    if (v > 13'd4096) return 13'd4096;
    return v;
  endfunction

  always_comb begin
    cfg_o.nb  = (batch_count_q == 7'd0) ? 7'd1 :
                (batch_count_q > 7'd64) ? 7'd64 : batch_count_q;
    cfg_o.ic  = clamp_size(in_channels_q);
    cfg_o.ih  = clamp_size(in_height_q);
    cfg_o.iw  = clamp_size(in_width_q);
    cfg_o.oc  = clamp_size(out_channels_q);
    cfg_o.r   = (upscale_q == 5'd0) ? 5'd1 :
                (upscale_q > 5'd16) ? 5'd16 : upscale_q;
    cfg_o.dcr = dcr_mode_q;
  end

endmodule

// ===== rtl/dts_ctrl.sv =====
// Sequencer of the address generator: accept, two multiply steps, output load.
// Depends on dts_pkg.
module dts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dts_pkg::dts_sts_t sts_i,
  output dts_pkg::dts_cmd_t cmd_o
);
  import dts_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_MUL_HI = 2'd1;
  localparam logic [1:0] ST_MUL_LO = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_MUL_HI;
        end
      end
      ST_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        // hold until the output register has room
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/dts_dp.sv =====
// Datapath: position counters, index multiply chain and output register.
// Depends on dts_pkg.
module dts_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  dts_pkg::dts_cfg_t            cfg_i,
  input  dts_pkg::dts_cmd_t            cmd_i,
  output dts_pkg::dts_sts_t            sts_o,
  input  logic [dts_pkg::ELEM_W-1:0]   element_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [dts_pkg::ELEM_W-1:0]   out_element_o,
  output logic [dts_pkg::OADDR_W-1:0]  out_address_o,
  output logic                         address_overflow_o,
  output logic                         last_o
);
  import dts_pkg::*;

  // Position counters
  logic [5:0]  batch_q, batch_d;
  logic [11:0] chan_q, chan_d;
  logic [11:0] row_q, row_d;
  logic [11:0] col_q, col_d;
  logic [11:0] dest_q, dest_d;
  logic [3:0]  srow_q, srow_d;
  logic [3:0]  scol_q, scol_d;
  logic        col_wrap, row_wrap, ch_wrap, b_wrap;

  // Pipeline registers
  logic [T1_W-1:0]   t1_q;
  logic [DIM_W-1:0]  oh_q, ow_q;
  logic [OFS_W-1:0]  rofs_q, cofs_q;
  logic [T2_W-1:0]   t2_q;
  logic [ELEM_W-1:0] elem_q;
  logic              last_q;
  logic [IDX_W-1:0]  idx;

  // Output register
  logic                out_valid_q;
  logic [ELEM_W-1:0]   out_elem_q;
  logic [OADDR_W-1:0]  out_addr_q;
  logic                out_ovf_q;
  logic                out_last_q;

  // Wrap conditions on the current position
  assign col_wrap = (13'(col_q) + 13'd1) >= cfg_i.iw;
  assign row_wrap = (13'(row_q) + 13'd1) >= cfg_i.ih;
  assign ch_wrap  = (13'(chan_q) + 13'd1) >= cfg_i.ic;
  assign b_wrap   = (7'(batch_q) + 7'd1) >= cfg_i.nb;

  // Counter stepping, column fastest
  always_comb begin
    batch_d = batch_q;
    chan_d  = chan_q;
    row_d   = row_q;
    col_d   = col_q;
    dest_d  = dest_q;
    srow_d  = srow_q;
    scol_d  = scol_q;
    if (!col_wrap) begin
      col_d = col_q + 12'd1;
    end else begin
      col_d = '0;
      if (!row_wrap) begin
        row_d = row_q + 12'd1;
      end else begin
        row_d = '0;
        if (!ch_wrap) begin
          chan_d = chan_q + 12'd1;
          if (cfg_i.dcr) begin
            // DCR: dest_channel fastest, then sub_col, then sub_row
            if ((13'(dest_q) + 13'd1) >= cfg_i.oc) begin
              dest_d = '0;
              if ((5'(scol_q) + 5'd1) >= cfg_i.r) begin
                scol_d = '0;
                srow_d = srow_q + 4'd1;
              end else begin
                scol_d = scol_q + 4'd1;
              end
            end else begin
              dest_d = dest_q + 12'd1;
            end
          end else begin
            // CRD: sub_col fastest, then sub_row, then dest_channel
            if ((5'(scol_q) + 5'd1) >= cfg_i.r) begin
              scol_d = '0;
              if ((5'(srow_q) + 5'd1) >= cfg_i.r) begin
                srow_d = '0;
                dest_d = dest_q + 12'd1;
              end else begin
                srow_d = srow_q + 4'd1;
              end
            end else begin
              scol_d = scol_q + 4'd1;
            end
          end
        end else begin
          chan_d  = '0;
          dest_d  = '0;
          srow_d  = '0;
          scol_d  = '0;
          batch_d = b_wrap ? 6'd0 : batch_q + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_q <= '0;
      chan_q  <= '0;
      row_q   <= '0;
      col_q   <= '0;
      dest_q  <= '0;
      srow_q  <= '0;
      scol_q  <= '0;
    end else if (cmd_i.accept) begin
      batch_q <= batch_d;
      chan_q  <= chan_d;
      row_q   <= row_d;
      col_q   <= col_d;
      dest_q  <= dest_d;
      srow_q  <= srow_d;
      scol_q  <= scol_d;
    end
  end

  // Stage one: products of the current position with the sizes
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      t1_q   <= T1_W'(batch_q) * T1_W'(cfg_i.oc) + T1_W'(dest_q);
      oh_q   <= DIM_W'(cfg_i.ih) * DIM_W'(cfg_i.r);
      ow_q   <= DIM_W'(cfg_i.iw) * DIM_W'(cfg_i.r);
      rofs_q <= OFS_W'(row_q) * OFS_W'(cfg_i.r) + OFS_W'(srow_q);
      cofs_q <= OFS_W'(col_q) * OFS_W'(cfg_i.r) + OFS_W'(scol_q);
      elem_q <= element_i & DATA_MASK;
      last_q <= col_wrap & row_wrap & ch_wrap & b_wrap;
    end
  end

  // Stage two: fold in the row
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_hi) begin
      t2_q <= T2_W'(t1_q) * T2_W'(oh_q) + T2_W'(rofs_q);
    end
  end

  // Stage three: fold in the column
  assign idx = IDX_W'(t2_q) * IDX_W'(ow_q) + IDX_W'(cofs_q);

  // Output register, free when empty or being drained
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_elem_q <= elem_q;
      out_addr_q <= OADDR_W'(idx & ADDR_MASK);
      out_ovf_q  <= |(idx & ~ADDR_MASK);
      out_last_q <= last_q;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_element_o      = out_elem_q;
  assign out_address_o      = out_addr_q;
  assign address_overflow_o = out_ovf_q;
  assign last_o             = out_last_q;

endmodule

// ===== rtl/depth_to_space_address_gen.sv =====
// Depth-to-space (pixel shuffle) address generator, DCR and CRD orderings.
// A new request is taken only once the last one is loaded into the output
// register, which output stalls can delay; this is set by the three-stage
// multiply chain of the index (position products, row fold, column fold).
// Reset: asynchronous, active low; clears counters, output valid and restores
// the register defaults. Depends on dts_pkg, dts_cfg, dts_ctrl and dts_dp.
module depth_to_space_address_gen (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [dts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dts_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // element requests
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [dts_pkg::ELEM_W-1:0]     element_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [dts_pkg::ELEM_W-1:0]     out_element_o,
  output logic [dts_pkg::OADDR_W-1:0]    out_address_o,
  output logic                           address_overflow_o,
  output logic                           last_o
);
  import dts_pkg::*;

  dts_cfg_t cfg;
  dts_cmd_t cmd;
  dts_sts_t sts;

  dts_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  dts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dts_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .element_i          (element_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_element_o      (out_element_o),
    .out_address_o      (out_address_o),
    .address_overflow_o (address_overflow_o),
    .last_o             (last_o)
  );

endmodule
